FILE: design/ppp_pkg.sv
// Package for the perspective point projection core: payload structs,
// field widths, codes, defaults and the 32-bit saturation helper.
// No dependencies.
`default_nettype none

package ppp_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int COORD_W    = 32;
    localparam int COEF_COUNT = 20;
    localparam int COEF_IDX_W = 5;
    localparam int DIM_W      = 10;
    localparam int NEAR_W     = 31;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DISTANCE = 2'd2;

    localparam logic [DIM_W-1:0]  SCREEN_COLS_RESET   = 10'd80;
    localparam logic [DIM_W-1:0]  SCREEN_ROWS_RESET   = 10'd24;
    localparam logic [NEAR_W-1:0] NEAR_DISTANCE_RESET = 31'd6554;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROJECT = 1'b1;

    // shared multiplier operand and accumulator widths
    localparam int MUL_AW = 35;
    localparam int MUL_BW = 33;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SAT_W  = ACC_W + 1;

    // viewport operand clamp, 2^33: beyond it the screen value saturates anyway
    localparam int VP_LIM_SHIFT = 33;

    typedef struct packed {
        logic                       action;
        logic [COEF_IDX_W-1:0]      coef_index;
        logic signed [COORD_W-1:0]  coef_value;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
    } ppp_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  screen_x;
        logic signed [COORD_W-1:0]  screen_y;
        logic signed [COORD_W-1:0]  view_depth;
        logic                       in_front;
        logic                       no_divide;
    } ppp_out_t;

    typedef struct packed {
        logic en;
        logic clr;
    } ppp_mac_ctl_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if ((&v[SAT_W-1:COORD_W-1]) || (~|v[SAT_W-1:COORD_W-1])) begin
            r = v[COORD_W-1:0];
        end
        else if (v[SAT_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/ppp_mac.sv
// Shared multiply-accumulate unit: one registered signed multiplier
// followed by an accumulator. Depends on ppp_pkg.
`default_nettype none

module ppp_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppp_pkg::ppp_mac_ctl_t               ctl,
    input  logic signed [ppp_pkg::MUL_AW-1:0]   a,
    input  logic signed [ppp_pkg::MUL_BW-1:0]   b,
    output logic signed [ppp_pkg::ACC_W-1:0]    acc
);
    import ppp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    ppp_mac_ctl_t             ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl_reg.en)
        begin
            acc_next = (ctl_reg.clr ? '0 : acc_reg)
                     + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: design/ppp_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per lane
// per cycle, truncating toward zero. Depends on ppp_pkg.
`default_nettype none

module ppp_div #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [ppp_pkg::COORD_W-1:0]      num_x,
    input  logic signed [ppp_pkg::COORD_W-1:0]      num_y,
    input  logic signed [ppp_pkg::COORD_W-1:0]      den,
    output logic                                    done,
    output logic signed [ppp_pkg::COORD_W+FRAC_BITS:0] quo_x,
    output logic signed [ppp_pkg::COORD_W+FRAC_BITS:0] quo_y
);
    import ppp_pkg::*;

    localparam int DW    = COORD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
    endfunction

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]      dvd_x_reg, dvd_x_next, dvd_y_reg, dvd_y_next;
    logic [COORD_W-1:0] rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [COORD_W-1:0] den_reg, den_next;
    logic               neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;

    logic [COORD_W:0]   rem_sh_x, rem_sh_y, den_ext;
    logic               ge_x, ge_y;

    always_comb
    begin
        den_ext  = {1'b0, den_reg};
        rem_sh_x = {rem_x_reg, dvd_x_reg[DW-1]};
        rem_sh_y = {rem_y_reg, dvd_y_reg[DW-1]};
        ge_x     = (rem_sh_x >= den_ext);
        ge_y     = (rem_sh_y >= den_ext);

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        dvd_x_next = dvd_x_reg;
        dvd_y_next = dvd_y_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        den_next   = den_reg;
        neg_x_next = neg_x_reg;
        neg_y_next = neg_y_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(DW);
            dvd_x_next = {mag(num_x), {FRAC_BITS{1'b0}}};
            dvd_y_next = {mag(num_y), {FRAC_BITS{1'b0}}};
            rem_x_next = '0;
            rem_y_next = '0;
            den_next   = mag(den);
            neg_x_next = num_x[COORD_W-1] ^ den[COORD_W-1];
            neg_y_next = num_y[COORD_W-1] ^ den[COORD_W-1];
        end
        else if (busy_reg)
        begin
            rem_x_next = ge_x ? COORD_W'(rem_sh_x - den_ext) : rem_sh_x[COORD_W-1:0];
            rem_y_next = ge_y ? COORD_W'(rem_sh_y - den_ext) : rem_sh_y[COORD_W-1:0];
            dvd_x_next = {dvd_x_reg[DW-2:0], ge_x};
            dvd_y_next = {dvd_y_reg[DW-2:0], ge_y};
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_x_reg <= dvd_x_next;
        dvd_y_reg <= dvd_y_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        den_reg   <= den_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
    end

    assign done  = done_reg;
    assign quo_x = neg_x_reg ? -$signed({1'b0, dvd_x_reg}) : $signed({1'b0, dvd_x_reg});
    assign quo_y = neg_y_reg ? -$signed({1'b0, dvd_y_reg}) : $signed({1'b0, dvd_y_reg});

endmodule

`default_nettype wire

FILE: design/perspective_point_projection_core.sv
// Perspective point projection core: sequencer, coefficient store, output register.
// Depends on ppp_pkg, ppp_mac and ppp_div.
// Project transfer: dot products for x, y, w and depth on the shared multiplier,
// a two-lane divide of x and y by w (skipped when w is zero), then viewport scaling;
// one item at a time, with in_ready low until the result is registered, longer while out stalls.
// Reset clears control and the configuration registers; coefficients are undefined until loaded.
`default_nettype none

module perspective_point_projection_core #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ppp_pkg::ppp_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ppp_pkg::ppp_out_t                   out_data
);
    import ppp_pkg::*;

    localparam int QW  = COORD_W + FRAC_BITS + 1;
    localparam int NXW = QW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DOT  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_VP   = 2'd3;

    localparam logic [1:0] SEL_X     = 2'd0;
    localparam logic [1:0] SEL_Y     = 2'd1;
    localparam logic [1:0] SEL_W     = 2'd2;
    localparam logic [1:0] SEL_DEPTH = 2'd3;

    localparam logic signed [MUL_BW-1:0] ONE_B    = MUL_BW'(1) << FRAC_BITS;
    localparam logic signed [NXW-1:0]    ONE_N    = NXW'(1) << FRAC_BITS;
    localparam logic signed [NXW-1:0]    VP_LIM_N = NXW'(1) << VP_LIM_SHIFT;
    localparam logic signed [MUL_AW-1:0] VP_LIM_A = MUL_AW'(1) << VP_LIM_SHIFT;

    function automatic logic signed [MUL_AW-1:0] clamp_vp(input logic signed [NXW-1:0] v);
        logic signed [MUL_AW-1:0] r;
        if (v > VP_LIM_N) begin
            r = VP_LIM_A;
        end
        else if (v < -VP_LIM_N) begin
            r = -VP_LIM_A;
        end
        else begin
            r = v[MUL_AW-1:0];
        end
        return r;
    endfunction

    logic [1:0]             state_reg, state_next;
    logic [2:0]             k_reg, k_next;
    logic [1:0]             sel_reg, sel_next;
    logic                   out_valid_reg, out_valid_next;
    ppp_out_t               out_data_reg, out_data_next;

    logic [DIM_W-1:0]       cols_reg, rows_reg;
    logic [NEAR_W-1:0]      near_reg;

    logic [COORD_W-1:0]     coef_mem [COEF_COUNT];
    logic [COORD_W-1:0]     coef_q_reg;
    logic [COEF_IDX_W-1:0]  rd_addr;
    logic [1:0]             row;

    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [COORD_W-1:0] hx_reg, hx_next, hy_reg, hy_next, hw_reg, hw_next;
    logic signed [COORD_W-1:0] depth_reg, depth_next, sx_reg, sx_next;
    logic                      front_reg, front_next;
    logic signed [MUL_AW-1:0]  vp_x_reg, vp_x_next, vp_y_reg, vp_y_next;

    logic                      issue_reg, issue_clr_reg;
    logic signed [MUL_BW-1:0]  b_reg, b_next;

    ppp_mac_ctl_t              mac_ctl;
    logic signed [MUL_AW-1:0]  mac_a;
    logic signed [MUL_BW-1:0]  mac_b;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   dres, half;
    logic signed [SAT_W-1:0]   neg_depth;

    logic                      div_start, div_done;
    logic signed [QW-1:0]      quo_x, quo_y;
    logic signed [NXW-1:0]     nx, ny;
    logic                      skip;
    logic                      in_xfer, load_wr;

    ppp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    ppp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_x (hx_reg),
        .num_y (hy_reg),
        .den   (hw_reg),
        .done  (div_done),
        .quo_x (quo_x),
        .quo_y (quo_y)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign load_wr  = in_xfer && (in_data.action == ACT_LOAD)
                   && (in_data.coef_index < COEF_IDX_W'(COEF_COUNT));
    assign skip     = (hw_reg == '0);

    always_comb
    begin
        row     = (sel_reg == SEL_W) ? 2'd3 : sel_reg;
        rd_addr = (sel_reg == SEL_DEPTH) ? {3'b100, k_reg[1:0]} : {1'b0, k_reg[1:0], row};
        case (k_reg[1:0])
            2'd0:    b_next = {px_reg[COORD_W-1], px_reg};
            2'd1:    b_next = {py_reg[COORD_W-1], py_reg};
            2'd2:    b_next = {pz_reg[COORD_W-1], pz_reg};
            default: b_next = ONE_B;
        endcase
    end

    always_comb
    begin
        if (state_reg == S_VP)
        begin
            mac_a       = k_reg[0] ? vp_y_reg : vp_x_reg;
            mac_b       = k_reg[0] ? MUL_BW'(rows_reg) : MUL_BW'(cols_reg);
            mac_ctl.en  = (k_reg < 3'd2);
            mac_ctl.clr = 1'b1;
        end
        else
        begin
            mac_a       = {{(MUL_AW-COORD_W){coef_q_reg[COORD_W-1]}}, coef_q_reg};
            mac_b       = b_reg;
            mac_ctl.en  = issue_reg;
            mac_ctl.clr = issue_clr_reg;
        end
    end

    always_comb
    begin
        dres      = acc >>> FRAC_BITS;
        half      = acc >>> 1;
        neg_depth = -{dres[ACC_W-1], dres};
        nx        = skip ? NXW'(hx_reg) : NXW'(quo_x);
        ny        = skip ? NXW'(hy_reg) : NXW'(quo_y);
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        sel_next       = sel_reg;
        hx_next        = hx_reg;
        hy_next        = hy_reg;
        hw_next        = hw_reg;
        depth_next     = depth_reg;
        front_next     = front_reg;
        sx_next        = sx_reg;
        vp_x_next      = vp_x_reg;
        vp_y_next      = vp_y_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (in_data.action == ACT_PROJECT))
                begin
                    state_next = S_DOT;
                    k_next     = 3'd0;
                    sel_next   = SEL_X;
                end
            end
            S_DOT:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd6)
                begin
                    k_next = 3'd0;
                    case (sel_reg)
                        SEL_X:   hx_next = sat32({dres[ACC_W-1], dres});
                        SEL_Y:   hy_next = sat32({dres[ACC_W-1], dres});
                        SEL_W:   hw_next = sat32({dres[ACC_W-1], dres});
                        default:
                        begin
                            depth_next = sat32(neg_depth);
                            front_next = neg_depth > $signed(SAT_W'(near_reg));
                        end
                    endcase
                    if (sel_reg == SEL_DEPTH)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end
            S_DIV:
            begin
                if (k_reg == 3'd0)
                begin
                    if (skip)
                    begin
                        state_next = S_VP;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        k_next    = 3'd1;
                    end
                end
                else if (div_done)
                begin
                    state_next = S_VP;
                    k_next     = 3'd0;
                end
                if ((k_reg == 3'd0 && skip) || (k_reg != 3'd0 && div_done))
                begin
                    vp_x_next = clamp_vp(nx + ONE_N);
                    vp_y_next = clamp_vp(ONE_N - ny);
                end
            end
            default:
            begin
                if (k_reg < 3'd3)
                begin
                    k_next = k_reg + 3'd1;
                end
                if (k_reg == 3'd2)
                begin
                    sx_next = sat32({half[ACC_W-1], half});
                end
                if (k_reg == 3'd3 && (!out_valid_reg || out_ready))
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.screen_x   = sx_reg;
                    out_data_next.screen_y   = sat32({half[ACC_W-1], half});
                    out_data_next.view_depth = depth_reg;
                    out_data_next.in_front   = front_reg;
                    out_data_next.no_divide  = skip;
                    state_next               = S_IDLE;
                    k_next                   = 3'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            sel_reg       <= SEL_X;
            out_valid_reg <= 1'b0;
            issue_reg     <= 1'b0;
            issue_clr_reg <= 1'b0;
            cols_reg      <= SCREEN_COLS_RESET;
            rows_reg      <= SCREEN_ROWS_RESET;
            near_reg      <= NEAR_DISTANCE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            issue_reg     <= (state_reg == S_DOT) && (k_reg < 3'd4);
            issue_clr_reg <= (k_reg == 3'd0);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCREEN_COLS:   cols_reg <= cfg_data[DIM_W-1:0];
                    CFG_SCREEN_ROWS:   rows_reg <= cfg_data[DIM_W-1:0];
                    CFG_NEAR_DISTANCE: near_reg <= cfg_data[NEAR_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            coef_mem[in_data.coef_index] <= in_data.coef_value;
        end
        coef_q_reg <= coef_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg <= in_data.point_x;
            py_reg <= in_data.point_y;
            pz_reg <= in_data.point_z;
        end
        b_reg        <= b_next;
        hx_reg       <= hx_next;
        hy_reg       <= hy_next;
        hw_reg       <= hw_next;
        depth_reg    <= depth_next;
        front_reg    <= front_next;
        sx_reg       <= sx_next;
        vp_x_reg     <= vp_x_next;
        vp_y_reg     <= vp_y_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: verif/perspective_point_projection_core_test.sv
// Self-checking testbench for perspective_point_projection_core: loads camera coefficients,
// projects points under random handshake pressure and checks every result transfer.
// Depends on ppp_pkg and the core RTL only.
module perspective_point_projection_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppp_pkg::*;

    localparam int     FB        = FRAC_BITS_DEFAULT;
    localparam longint ONE       = longint'(1) << FB;
    localparam longint NDC_LIM   = longint'(1) << 40;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;
    localparam int     DRAIN     = 150;
    localparam int     IDLE_LIMIT = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    ppp_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    ppp_out_t              out_data;

    logic signed [COORD_W-1:0] coef_store [COEF_COUNT];
    logic [DIM_W-1:0]          exp_cols;
    logic [DIM_W-1:0]          exp_rows;
    logic [NEAR_W-1:0]         exp_near;
    ppp_out_t                  projections [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches = 0;
    int idle_cycles = 0;

    perspective_point_projection_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic longint clip32(input longint v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic longint clip_ndc(input longint v);
        if (v > NDC_LIM)
        begin
            return NDC_LIM;
        end
        if (v < -NDC_LIM)
        begin
            return -NDC_LIM;
        end
        return v;
    endfunction

    // exact four-term dot product, floored back to Q16.16
    function automatic longint weigh_row(input int first, input int stride, input ppp_in_t p);
        logic signed [71:0] acc;
        longint term [4];
        term[0] = longint'($signed(p.point_x));
        term[1] = longint'($signed(p.point_y));
        term[2] = longint'($signed(p.point_z));
        term[3] = ONE;
        acc = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc = acc + longint'(coef_store[first + k*stride]) * term[k];
        end
        return longint'(acc >>> FB);
    endfunction

    function automatic ppp_out_t project_point(input ppp_in_t p);
        ppp_out_t r;
        longint hx, hy, hw, depth, nx, ny, sx, sy, cw, rh, nd;
        hx = clip32(weigh_row(0, 4, p));
        hy = clip32(weigh_row(1, 4, p));
        hw = clip32(weigh_row(3, 4, p));
        depth = -weigh_row(16, 1, p);
        cw = exp_cols;
        rh = exp_rows;
        nd = exp_near;
        if (hw == 0)
        begin
            nx = hx;
            ny = hy;
        end
        else
        begin
            nx = clip_ndc((hx * ONE) / hw);
            ny = clip_ndc((hy * ONE) / hw);
        end
        sx = ((nx + ONE) * cw) >>> 1;
        sy = ((ONE - ny) * rh) >>> 1;
        r.screen_x   = 32'(clip32(sx));
        r.screen_y   = 32'(clip32(sy));
        r.view_depth = 32'(clip32(depth));
        r.in_front   = depth > nd;
        r.no_divide  = hw == 0;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_coord(input int span);
        logic [31:0] lim;
        if (span >= 31)
        begin
            return $urandom;
        end
        lim = 32'd1 << span;
        return $urandom_range(2*lim) - lim;
    endfunction

    function automatic ppp_in_t load_item(input int idx, input logic signed [31:0] value);
        ppp_in_t it;
        it.action     = ACT_LOAD;
        it.coef_index = COEF_IDX_W'(idx);
        it.coef_value = value;
        it.point_x    = $urandom;
        it.point_y    = $urandom;
        it.point_z    = $urandom;
        return it;
    endfunction

    function automatic ppp_in_t point_item(input logic signed [31:0] x, y, z);
        ppp_in_t it;
        it.action     = ACT_PROJECT;
        it.coef_index = COEF_IDX_W'($urandom);
        it.coef_value = $urandom;
        it.point_x    = x;
        it.point_y    = y;
        it.point_z    = z;
        return it;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(3))
            0: return 10'd1;
            1: return 10'd1023;
            default: return DIM_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [NEAR_W-1:0] pick_near();
        case ($urandom_range(3))
            0: return '0;
            1: return {NEAR_W{1'b1}};
            default: return NEAR_W'($urandom_range(1 << 20));
        endcase
    endfunction

    task automatic send_item(input ppp_in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (item.action == ACT_PROJECT)
        begin
            projections.insert(projections.size(), project_point(item));
        end
        else if (item.coef_index < COEF_COUNT)
        begin
            coef_store[item.coef_index] = item.coef_value;
        end
    endtask

    // block idle: nothing pending, and any trailing load given time to finish
    task automatic settle();
        in_valid <= 1'b0;
        while (projections.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_canvas(input logic [DIM_W-1:0] cols, rows,
                              input logic [NEAR_W-1:0] near_q);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_COLS;
        cfg_data  <= CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_index <= CFG_SCREEN_ROWS;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= CFG_NEAR_DISTANCE;
        cfg_data  <= CFG_DATA_W'(near_q);
        @(posedge clk);
        cfg_we <= 1'b0;
        exp_cols = cols;
        exp_rows = rows;
        exp_near = near_q;
    endtask

    task automatic test_matrix_load();
        logic signed [31:0] camera [COEF_COUNT];
        // row 2 is never used by the projection, so it carries the extreme values
        camera = '{32'sd98304, 32'sd0, 32'sh7FFFFFFF, 32'sd0,
                   32'sd0, 32'sd131072, 32'sh80000000, 32'sd0,
                   32'sd0, 32'sd0, -32'sd1234567, -32'sd65536,
                   32'sd16384, -32'sd32768, 32'sd65536, 32'sd0,
                   32'sd0, 32'sd0, 32'sd65536, 32'sd32768};
        for (int i = 0; i < COEF_COUNT; i++)
        begin
            send_item(load_item(i, camera[i]));
        end
    endtask

    task automatic test_point_extremes();
        send_item(point_item(32'sd65536, 32'sd32768, -32'sd262144));
        send_item(point_item(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000));
        send_item(point_item(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        send_item(point_item(32'sd0, 32'sd0, 32'sd0));
    endtask

    task automatic test_zero_w();
        send_item(load_item(11, 32'sd0));
        send_item(point_item(32'sd65536, -32'sd131072, -32'sd196608));
        send_item(load_item(11, -32'sd65536));
    endtask

    task automatic test_ignored_index();
        send_item(load_item(20, 32'sh12345678));
        send_item(load_item(31, -32'sd1));
        send_item(point_item(32'sd32768, 32'sd32768, -32'sd131072));
    endtask

    task automatic test_canvas_extremes();
        settle();
        set_canvas(10'd0, 10'd1023, '0);
        send_item(point_item(-32'sd49152, 32'sd98304, -32'sd131072));
        send_item(point_item(32'sd16384, -32'sd8192, 32'sd65536));
        settle();
        set_canvas(10'd1023, 10'd0, {NEAR_W{1'b1}});
        send_item(point_item(32'sd65536, 32'sd65536, -32'sd65536));
        send_item(point_item(32'sh7FFFFFFF, -32'sd1, 32'sh80000000));
    endtask

    task automatic test_random(input int send_pct, input int stall_pct, input int n_items);
        int sent;
        int style;
        int span;
        int burst;
        logic signed [31:0] v;
        settle();
        set_canvas(pick_dim(), pick_dim(), pick_near());
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            // full camera reload: mostly small values, some full range, some with w row zero
            if ($urandom_range(2) == 0)
            begin
                style = $urandom_range(5);
                for (int i = 0; i < COEF_COUNT; i++)
                begin
                    if (style == 4)
                        v = $urandom;
                    else if (style == 5 && i % 4 == 3 && i < 16)
                        v = '0;
                    else
                        v = rand_coord($urandom_range(1) ? 18 : 12);
                    send_item(load_item(i, v));
                end
                sent += COEF_COUNT;
            end
            burst = $urandom_range(24, 8);
            for (int j = 0; j < burst; j++)
            begin
                case ($urandom_range(19))
                    0:
                    begin
                        send_item(load_item($urandom_range(31, COEF_COUNT), $urandom));
                    end
                    1, 2:
                    begin
                        send_item(load_item($urandom_range(COEF_COUNT-1), rand_coord(18)));
                        sent++;
                    end
                    default:
                    begin
                        span = ($urandom_range(4) == 0) ? 32 : $urandom_range(20, 8);
                        send_item(point_item(rand_coord(span), rand_coord(span),
                                             rand_coord(span)));
                        sent++;
                    end
                endcase
            end
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        ppp_out_t want;
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            if (projections.size() == 0)
            begin
                $error("result transfer with no projection pending");
                mismatches++;
            end
            else
            begin
                want = projections.pop_front();
                check_field("screen_x", want.screen_x, out_data.screen_x);
                check_field("screen_y", want.screen_y, out_data.screen_y);
                check_field("view_depth", want.view_depth, out_data.view_depth);
                check_field("in_front", want.in_front, out_data.in_front);
                check_field("no_divide", want.no_divide, out_data.no_divide);
            end
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        exp_cols       = SCREEN_COLS_RESET;
        exp_rows       = SCREEN_ROWS_RESET;
        exp_near       = NEAR_DISTANCE_RESET;
        send_idle_pct  = 33;
        recv_stall_pct = 83;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_matrix_load();
        test_point_extremes();
        test_zero_w();
        test_ignored_index();
        test_canvas_extremes();
        test_random(33, 83, 155);
        test_random(83, 33, 155);
        test_random(0, 0, 155);
        settle();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
